>>> hdl/chs_pkg.sv
// Package for the compass heading block: widths, angle table and constants.
// Holds the vector type handed between the CORDIC cells; no dependencies.
package chs_pkg;

  localparam int unsigned IN_W   = 16;
  localparam int unsigned HEAD_W = 15;
  localparam int unsigned DECL_W = 15;
  localparam int unsigned XW     = 36;
  localparam int unsigned ZW     = 25;
  localparam int unsigned TAB_W  = 22;
  localparam int unsigned TAB_LEN = 24;
  localparam int unsigned T_W    = 13;
  localparam int unsigned H_W    = 17;

  localparam logic signed [IN_W-1:0] AXIS_LIMIT = 16'sh07FF;

  localparam logic [ZW-1:0]  Z_MAX      = 25'd5898240;
  localparam logic [ZW-1:0]  ROUND_HALF = 25'd512;
  localparam int unsigned    FRAC_SHIFT = 10;

  localparam logic signed [H_W-1:0] HALF_TURN     = 17'sd11520;
  localparam logic signed [H_W-1:0] QUARTER       = 17'sd5760;
  localparam logic signed [H_W-1:0] THREE_QUARTER = 17'sd17280;
  localparam logic signed [H_W-1:0] FULL_TURN     = 17'sd23040;

  localparam logic [TAB_W-1:0] ATAN_TAB [TAB_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
    22'd234379,  22'd117304,  22'd58666,  22'd29335,
    22'd14668,   22'd7334,    22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,
    22'd57,      22'd29,      22'd14,     22'd7,
    22'd4,       22'd2,       22'd1,      22'd0
  };

  typedef struct packed {
    logic y_zero;
    logic y_pos;
    logic x_pos;
    logic x_zero;
    logic flip;
  } flags_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    flags_t               f;
  } vec_t;

endpackage

>>> hdl/chs_prep.sv
// Input stage: folds large axis values, takes magnitudes, seeds the CORDIC vector.
// Depends on chs_pkg.
module chs_prep
  import chs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [IN_W-1:0] field_x_i,
  input  logic signed [IN_W-1:0] field_y_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output vec_t                   out_data_o
);

  logic               vld_q;
  vec_t               data_q, data_d;
  logic signed [IN_W-1:0] xs, ys;
  logic signed [IN_W:0]   xe, ye;
  logic [IN_W:0]          ax, ay;

  assign in_ready_o = !vld_q || out_ready_i;

  always_comb begin
    xs = (field_x_i > AXIS_LIMIT) ? ~field_x_i : field_x_i;
    ys = (field_y_i > AXIS_LIMIT) ? ~field_y_i : field_y_i;
    xe = {xs[IN_W-1], xs};
    ye = {ys[IN_W-1], ys};
    ax = xe[IN_W] ? (-xe) : xe;
    ay = ye[IN_W] ? (-ye) : ye;
    data_d.x        = signed'({{(XW-IN_W-17){1'b0}}, ay, 16'h0000});
    data_d.y        = signed'({{(XW-IN_W-17){1'b0}}, ax, 16'h0000});
    data_d.z        = '0;
    data_d.f.y_zero = (ys == '0);
    data_d.f.y_pos  = !ys[IN_W-1] && (ys != '0);
    data_d.f.x_pos  = !xs[IN_W-1] && (xs != '0);
    data_d.f.x_zero = (xs == '0);
    data_d.f.flip   = xs[IN_W-1] ^ ys[IN_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

>>> hdl/chs_cell.sv
// One CORDIC vectoring cell: a fixed shift and table angle, one register stage.
// Depends on chs_pkg.
module chs_cell
  import chs_pkg::*;
#(
  parameter int unsigned Idx = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  vec_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output vec_t out_data_o
);

  logic               vld_q;
  vec_t               data_q, data_d;
  logic signed [XW-1:0] xi, yi, dx, dy;
  logic signed [ZW-1:0] zi, ang;

  assign in_ready_o = !vld_q || out_ready_i;

  always_comb begin
    xi  = in_data_i.x;
    yi  = in_data_i.y;
    zi  = in_data_i.z;
    dx  = yi >>> Idx;
    dy  = xi >>> Idx;
    ang = signed'({{(ZW-TAB_W){1'b0}}, ATAN_TAB[Idx]});
    data_d.f = in_data_i.f;
    if (!yi[XW-1]) begin
      data_d.x = xi + dx;
      data_d.y = yi - dy;
      data_d.z = zi + ang;
    end else begin
      data_d.x = xi - dx;
      data_d.y = yi + dy;
      data_d.z = zi - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

>>> hdl/chs_post.sv
// Output stages: clamp and round the angle, then form, correct and wrap the heading.
// Depends on chs_pkg.
module chs_post
  import chs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  vec_t                     in_data_i,
  input  logic signed [DECL_W-1:0] decl_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [HEAD_W-1:0]        heading_o
);

  logic                 vld_a_q, vld_b_q, rdy_b;
  logic [T_W-1:0]       t_q, t_d;
  flags_t               f_q;
  logic [HEAD_W-1:0]    heading_q, heading_d;
  logic [ZW-1:0]        zc, rnd;
  logic signed [T_W:0]  tn;
  logic signed [H_W-1:0] base, h, sum, wrap;

  assign rdy_b      = !vld_b_q || out_ready_i;
  assign in_ready_o = !vld_a_q || rdy_b;

  always_comb begin
    if (in_data_i.z[ZW-1]) begin
      zc = '0;
    end else if (unsigned'(in_data_i.z) > Z_MAX) begin
      zc = Z_MAX;
    end else begin
      zc = unsigned'(in_data_i.z);
    end
    rnd = zc + ROUND_HALF;
    t_d = in_data_i.f.x_zero ? '0 : rnd[FRAC_SHIFT +: T_W];
  end

  always_comb begin
    tn   = f_q.flip ? -signed'({1'b0, t_q}) : signed'({1'b0, t_q});
    base = f_q.y_pos ? QUARTER : THREE_QUARTER;
    if (f_q.y_zero) begin
      h = f_q.x_pos ? HALF_TURN : '0;
    end else begin
      h = base - {{(H_W-T_W-1){tn[T_W]}}, tn};
    end
    sum = h + {{(H_W-DECL_W){decl_i[DECL_W-1]}}, decl_i};
    priority if (sum[H_W-1]) begin
      wrap = sum + FULL_TURN;
    end else if (sum >= FULL_TURN) begin
      wrap = sum - FULL_TURN;
    end else begin
      wrap = sum;
    end
    heading_d = wrap[HEAD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        vld_a_q <= in_valid_i;
      end
      if (rdy_b) begin
        vld_b_q <= vld_a_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      t_q <= t_d;
      f_q <= in_data_i.f;
    end
    if (rdy_b && vld_a_q) begin
      heading_q <= heading_d;
    end
  end

  assign out_valid_o = vld_b_q;
  assign heading_o   = heading_q;

endmodule

>>> hdl/compass_heading_from_field_top.sv
// Top level of the compass heading block: input stage, CORDIC cell row, output stages.
// Depends on chs_pkg, chs_prep, chs_cell and chs_post.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) transfers one raw X/Y field sample.
//   Output channel (out_valid_o/out_ready_i) transfers one heading in 1/64 degree,
//   0 to 23039. Results leave in the order the samples came in.
//   Config channel (cfg_valid_i/cfg_ready_o) writes the signed declination; it is
//   always ready and should be written only while no sample is in flight.
//   A sample passes one input stage, one register stage per CORDIC cell, one rounding
//   stage and the output register.
//   Throughput is one sample per cycle while out_ready_i is high; each stage holds one
//   sample, so the cells set the latency, and a free stage takes a new sample each cycle.
//   Reset empties every stage and sets the declination to zero.
//   When the receiver stalls, the output register holds its heading and the
//   stages behind it keep filling; in_ready_o drops only once all are full.
module compass_heading_from_field_top
  import chs_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [IN_W-1:0]   field_x_i,
  input  logic signed [IN_W-1:0]   field_y_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [HEAD_W-1:0]        heading_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic signed [DECL_W-1:0] cfg_declination_i
);

  logic signed [DECL_W-1:0] decl_q;
  vec_t                     chain_data [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]    chain_vld;
  logic [CORDIC_STEPS:0]    chain_rdy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decl_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      decl_q <= cfg_declination_i;
    end
  end

  chs_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .field_x_i   (field_x_i),
    .field_y_i   (field_y_i),
    .out_valid_o (chain_vld[0]),
    .out_ready_i (chain_rdy[0]),
    .out_data_o  (chain_data[0])
  );

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    chs_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_vld[g]),
      .in_ready_o  (chain_rdy[g]),
      .in_data_i   (chain_data[g]),
      .out_valid_o (chain_vld[g+1]),
      .out_ready_i (chain_rdy[g+1]),
      .out_data_o  (chain_data[g+1])
    );
  end

  chs_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_vld[CORDIC_STEPS]),
    .in_ready_o  (chain_rdy[CORDIC_STEPS]),
    .in_data_i   (chain_data[CORDIC_STEPS]),
    .decl_i      (decl_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .heading_o   (heading_o)
  );

endmodule

>>> hdl/chs_checker.sv
// Port-level checks for the compass heading block, bound to the top level.
// Depends on chs_pkg and compass_heading_from_field_top.
module chs_checker
  import chs_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [HEAD_W-1:0]        heading_o,
  input logic                     cfg_valid_i,
  input logic                     cfg_ready_o
);

  a_heading_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (heading_o < 15'd23040))
    else $error("heading out of range");

  a_empty_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  a_drain_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input stalled while output drains");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(heading_o)))
    else $error("stalled result changed");

  a_cfg_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration transfer refused");

endmodule

bind compass_heading_from_field_top chs_checker u_chs_checker (.*);

>>> verif/testbench.sv
// Self-checking testbench for compass_heading_from_field_top: queued samples,
// a handshake driver and monitor, and a bit-exact heading predictor.
// Depends on chs_pkg and the compass heading RTL only.
module testbench
  import chs_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STEPS       = 16;
  localparam int unsigned LATENCY     = STEPS + 3;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 211;

  localparam int AXIS_MAX       = 2047;
  localparam int DEG90_64K      = 90 * 65536;
  localparam int TURN_64        = 23040;
  localparam int HALF_64        = 11520;
  localparam int QUARTER_64     = 5760;
  localparam int THREE_QUART_64 = 17280;

  localparam longint ATAN_64K [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  localparam int DIR_X [25] = '{
    0, 1, -1, 2047, 2048, 0, 0, 0, 0, 32767, -32768, 2047, 2048,
    2047, 2047, -32768, 1, -1, 1, -1, 1, -1, 32767, 100, 2047
  };
  localparam int DIR_Y [25] = '{
    0, 0, 0, 0, 0, 1, -1, 32767, -32768, 32767, -32768, 2047, 2048,
    -1, 1, 1, -32768, 2047, 1, -1, -1, 1, 1, -100, 2048
  };

  localparam int DECL_EDGE [9] = '{-16384, 16383, 0, -11520, 11519, 0, 5760, -5760, 0};

  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
  } sample_t;

  logic                     clk_i;
  logic                     rst_ni    = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready_o;
  logic signed [IN_W-1:0]   field_x   = '0;
  logic signed [IN_W-1:0]   field_y   = '0;
  logic                     out_valid_o;
  logic                     out_ready = 1'b0;
  logic [HEAD_W-1:0]        heading_o;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready_o;
  logic signed [DECL_W-1:0] cfg_decl  = '0;

  sample_t                  sample_q [$];
  logic [HEAD_W-1:0]        heading_q [$];
  logic signed [DECL_W-1:0] decl_now  = '0;
  int unsigned              snd_idle  = 0;
  int unsigned              rcv_idle  = 0;
  int unsigned              stall_cycles = 0;
  bit                       failed    = 1'b0;

  compass_heading_from_field_top #(
    .CORDIC_STEPS(STEPS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .field_x_i        (field_x),
    .field_y_i        (field_y),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .heading_o        (heading_o),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_declination_i(cfg_decl)
  );

  function automatic logic [HEAD_W-1:0] heading_of(input logic signed [IN_W-1:0] fx,
                                                   input logic signed [IN_W-1:0] fy,
                                                   input logic signed [DECL_W-1:0] decl);
    int     sx, sy, ang, h;
    longint vx, vy, vz, dx, dy;
    sx = fx;
    sy = fy;
    if (sx > AXIS_MAX) sx = -sx - 1;
    if (sy > AXIS_MAX) sy = -sy - 1;
    if (sy == 0) begin
      h = (sx > 0) ? HALF_64 : 0;
    end else begin
      ang = 0;
      if (sx != 0) begin
        vx = (sy < 0) ? -longint'(sy) : longint'(sy);
        vy = (sx < 0) ? -longint'(sx) : longint'(sx);
        vx = vx * 65536;
        vy = vy * 65536;
        vz = 0;
        for (int i = 0; i < STEPS && i < 24; i++) begin
          dx = vy >>> i;
          dy = vx >>> i;
          if (vy >= 0) begin
            vx += dx;
            vy -= dy;
            vz += ATAN_64K[i];
          end else begin
            vx -= dx;
            vy += dy;
            vz -= ATAN_64K[i];
          end
        end
        if (vz < 0) vz = 0;
        if (vz > DEG90_64K) vz = DEG90_64K;
        ang = int'((vz + 512) >>> 10);
        if ((sx < 0) != (sy < 0)) ang = -ang;
      end
      h = (sy > 0) ? (QUARTER_64 - ang) : (THREE_QUART_64 - ang);
    end
    h += int'(decl);
    if (h < 0) h += TURN_64;
    if (h >= TURN_64) h -= TURN_64;
    return h[HEAD_W-1:0];
  endfunction

  function automatic logic signed [IN_W-1:0] draw_axis();
    case ($urandom_range(7))
      0, 1, 2: return IN_W'($urandom);
      3:       return IN_W'(int'($urandom_range(4095)) - 2048);
      4:       return IN_W'(int'($urandom_range(15)) + 2040);
      5:       return IN_W'(int'($urandom_range(16)) - 8);
      6:       return '0;
      default: begin
        case ($urandom_range(3))
          0:       return 16'sh8000;
          1:       return 16'sh7FFF;
          2:       return -16'sd1;
          default: return 16'sd1;
        endcase
      end
    endcase
  endfunction

  task automatic write_declination(input logic signed [DECL_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_decl  <= d;
    do @(posedge clk_i); while (!(cfg_valid && cfg_ready_o));
    decl_now = d;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid || heading_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : drive
    sample_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) heading_q.push_back(heading_of(field_x, field_y, decl_now));
      if (!in_valid || in_ready_o) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= snd_idle) begin
          nxt = sample_q.pop_front();
          in_valid <= 1'b1;
          field_x  <= nxt.x;
          field_y  <= nxt.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk_i) begin : check
    logic [HEAD_W-1:0] want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (heading_q.size() == 0) begin
        $error("heading: no transfer expected, got %0d", heading_o);
        failed = 1'b1;
      end else begin
        want = heading_q.pop_front();
        if (heading_o !== want) begin
          $error("heading: expected %0d, got %0d", want, heading_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)
        || (cfg_valid && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("** compass_heading_from_field_top: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    snd_idle = 20;
    rcv_idle = 73;
    for (int k = 0; k < 25; k++) begin
      sample_q.push_back('{x: IN_W'(DIR_X[k]), y: IN_W'(DIR_Y[k])});
    end
    drain();

    for (int p = 0; p < 9; p++) begin
      case (p / 3)
        0: begin
          snd_idle = 20;
          rcv_idle = 73;
        end
        1: begin
          snd_idle = 73;
          rcv_idle = 20;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      @(posedge clk_i);
      if (p % 3 == 2) write_declination(DECL_W'($urandom));
      else write_declination(DECL_W'(DECL_EDGE[p]));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        sample_q.push_back('{x: draw_axis(), y: draw_axis()});
      end
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk_i);
    if (!failed && heading_q.size() == 0) begin
      $display("** compass_heading_from_field_top: PASSED **");
    end else begin
      $display("** compass_heading_from_field_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/chs_pkg.sv
hdl/chs_prep.sv
hdl/chs_cell.sv
hdl/chs_post.sv
hdl/compass_heading_from_field_top.sv
hdl/chs_checker.sv
verif/testbench.sv
